FILE: hw/rtl/pgl_pkg.sv
// shared constants, types and width helpers for the pcm16 gain and lowpass block
package pgl_pkg;

   // default number of coefficient fraction bits
   localparam int COEF_FRAC_BITS_DEF = 16;

   // fixed field widths
   localparam int SAMPLE_W = 16;
   localparam int GAIN_W   = 24;
   localparam int ALPHA_W  = 17;
   localparam int CSR_IDX_W = 2;

   // register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] REG_MODE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ALPHA = 2'd2;

   // mode codes
   localparam logic MODE_GAIN    = 1'b0;
   localparam logic MODE_LOWPASS = 1'b1;

   // sample limits
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX     = 16'sd32767;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_NEG_MAX = -16'sd32767;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MOST_NEG = 16'sh8000;

   // control handed to the filter stage
   typedef struct packed {
      logic load;
      logic mode;
   } pgl_ctrl_type;

   // running value width
   function automatic int fv_width(input int frac);
      return 17 + frac;
   endfunction

   // gain register must also hold the reset value of one
   function automatic int gain_reg_width(input int frac);
      return (GAIN_W > frac + 2) ? GAIN_W : frac + 2;
   endfunction

   // alpha register must also hold the reset value of one
   function automatic int alpha_reg_width(input int frac);
      return (ALPHA_W > frac + 1) ? ALPHA_W : frac + 1;
   endfunction

   // gain product width
   function automatic int gprod_width(input int frac);
      return SAMPLE_W + gain_reg_width(frac);
   endfunction

endpackage

FILE: hw/rtl/pcm16_gain_and_one_pole_lowpass.sv
// top level: pcm16 gain or one-pole lowpass with rounding and symmetric clamp
// one item per cycle sustained while rsp_tready is high
// the running value's subtract, multiply, round and add loop closes around fv_ff
// stages: input register, multiply/state register, round and clamp into the output register
// synchronous active high reset clears valid flags and running value, config to defaults
// configuration writes are always taken (csr_ready is high)
module pcm16_gain_and_one_pole_lowpass #(
   parameter int COEF_FRAC_BITS = pgl_pkg::COEF_FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [15:0]                       req_tdata,  // [15:0] sample_in
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [15:0]                       rsp_tdata,  // [15:0] sample_out
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [pgl_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pgl_pkg::GAIN_W-1:0]        csr_data
);

   localparam int F       = COEF_FRAC_BITS;
   localparam int SW      = pgl_pkg::SAMPLE_W;
   localparam int GW      = pgl_pkg::gain_reg_width(F);
   localparam int AW      = pgl_pkg::alpha_reg_width(F);
   localparam int FV_W    = pgl_pkg::fv_width(F);
   localparam int GPROD_W = pgl_pkg::gprod_width(F);
   localparam int CW      = (GPROD_W > FV_W) ? GPROD_W : FV_W;
   localparam int SAT_W   = CW - F + 1;

   localparam logic signed [SAT_W-1:0] OUT_HI = {{(SAT_W-15){1'b0}}, {15{1'b1}}};
   localparam logic signed [SAT_W-1:0] OUT_LO = -OUT_HI;

   logic                      mode_ff, mode_in;
   logic signed [GW-1:0]      gain_ff, gain_in;
   logic [AW-1:0]             alpha_ff, alpha_in;
   logic                      va_ff, va_in;
   logic                      vb_ff, vb_in;
   logic                      vc_ff, vc_in;
   logic signed [SW-1:0]      sample_ff, sample_in;
   logic [15:0]               out_ff, out_in;
   logic                      ready_a, ready_b, ready_c;
   logic                      load_b;
   pgl_pkg::pgl_ctrl_type     fctrl;
   logic signed [FV_W-1:0]    fv;
   logic signed [GPROD_W-1:0] gprod;
   logic signed [CW-1:0]      sel_val;
   logic signed [SAT_W-1:0]   rounded;

   // configuration registers
   assign csr_ready = 1'b1;

   always_comb begin
      mode_in  = mode_ff;
      gain_in  = gain_ff;
      alpha_in = alpha_ff;
      if (csr_valid) begin
         case (csr_index)
            pgl_pkg::REG_MODE: begin
               mode_in = csr_data[0];
            end
            pgl_pkg::REG_GAIN: begin
               gain_in = $signed({{(GW-pgl_pkg::GAIN_W){csr_data[pgl_pkg::GAIN_W-1]}},
                                  csr_data});
            end
            pgl_pkg::REG_ALPHA: begin
               alpha_in = {{(AW-pgl_pkg::ALPHA_W){1'b0}}, csr_data[pgl_pkg::ALPHA_W-1:0]};
            end
            default: begin
            end
         endcase
      end
   end

   // per-stage flow control
   assign ready_c    = !vc_ff || rsp_tready;
   assign ready_b    = !vb_ff || ready_c;
   assign ready_a    = !va_ff || ready_b;
   assign req_tready = ready_a;
   assign load_b     = va_ff && ready_b;

   assign va_in = ready_a ? req_tvalid : va_ff;
   assign vb_in = ready_b ? va_ff : vb_ff;
   assign vc_in = ready_c ? vb_ff : vc_ff;

   // most negative input treated as its symmetric limit
   assign sample_in = ($signed(req_tdata) == pgl_pkg::SAMPLE_MOST_NEG) ?
                      pgl_pkg::SAMPLE_NEG_MAX : $signed(req_tdata);

   // multiply and state update stage
   assign fctrl.load = load_b;
   assign fctrl.mode = mode_ff;

   pgl_filter #(
      .FRAC (F)
   ) u_filter (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (fctrl),
      .sample       (sample_ff),
      .gain_coeff   (gain_ff),
      .alpha_coeff  (alpha_ff),
      .filter_value (fv),
      .gain_prod    (gprod)
   );

   // pick the stage value, round and clamp
   assign sel_val = (mode_ff == pgl_pkg::MODE_LOWPASS) ?
                    $signed({{(CW-FV_W){fv[FV_W-1]}}, fv}) :
                    $signed({{(CW-GPROD_W){gprod[GPROD_W-1]}}, gprod});

   pgl_round #(
      .W    (CW),
      .FRAC (F)
   ) u_out_round (
      .value_in (sel_val),
      .result   (rounded)
   );

   always_comb begin
      if (rounded > OUT_HI) begin
         out_in = OUT_HI[15:0];
      end else if (rounded < OUT_LO) begin
         out_in = OUT_LO[15:0];
      end else begin
         out_in = rounded[15:0];
      end
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= pgl_pkg::MODE_GAIN;
         gain_ff  <= GW'(1) << F;
         alpha_ff <= AW'(1) << F;
         va_ff    <= 1'b0;
         vb_ff    <= 1'b0;
         vc_ff    <= 1'b0;
      end else begin
         mode_ff  <= mode_in;
         gain_ff  <= gain_in;
         alpha_ff <= alpha_in;
         va_ff    <= va_in;
         vb_ff    <= vb_in;
         vc_ff    <= vc_in;
      end
      if (req_tvalid && ready_a) begin
         sample_ff <= sample_in;
      end
      if (vb_ff && ready_c) begin
         out_ff <= out_in;
      end
   end

   assign rsp_tvalid = vc_ff;
   assign rsp_tdata  = out_ff;

   // checks
   a_no_most_neg: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata != 16'h8000))
      else $error("result holds the most negative code");

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (va_ff && vb_ff && vc_ff && !rsp_tready) |-> !req_tready)
      else $error("input taken while every stage is full and stalled");

   a_fv_hold: assert property (@(posedge clock) disable iff (reset)
      !(load_b && (mode_ff == pgl_pkg::MODE_LOWPASS)) |=> $stable(fv))
      else $error("running value changed without a lowpass item");

endmodule

FILE: hw/rtl/pgl_round.sv
// divide by a power of two with round half to even
module pgl_round #(
   parameter int W    = 40,
   parameter int FRAC = 16
) (
   input  logic signed [W-1:0]    value_in,
   output logic signed [W-FRAC:0] result
);

   localparam logic [FRAC-1:0] HALF = {1'b1, {(FRAC-1){1'b0}}};

   logic signed [W-FRAC-1:0] floor_val;
   logic [FRAC-1:0]          rem;
   logic                     inc;

   // floor quotient plus increment above half or at half when odd
   assign floor_val = value_in[W-1:FRAC];
   assign rem       = value_in[FRAC-1:0];
   assign inc       = (rem > HALF) || ((rem == HALF) && floor_val[0]);
   assign result    = $signed({floor_val[W-FRAC-1], floor_val})
                    + $signed({{(W-FRAC){1'b0}}, inc});

endmodule

FILE: hw/rtl/pgl_filter.sv
// gain multiply and one-pole lowpass state update stage
module pgl_filter #(
   parameter int FRAC = pgl_pkg::COEF_FRAC_BITS_DEF
) (
   input  logic                                               clock,
   input  logic                                               reset,
   input  pgl_pkg::pgl_ctrl_type                              ctrl,
   input  logic signed [pgl_pkg::SAMPLE_W-1:0]                sample,
   input  logic signed [pgl_pkg::gain_reg_width(FRAC)-1:0]    gain_coeff,
   input  logic [pgl_pkg::alpha_reg_width(FRAC)-1:0]          alpha_coeff,
   output logic signed [pgl_pkg::fv_width(FRAC)-1:0]          filter_value,
   output logic signed [pgl_pkg::gprod_width(FRAC)-1:0]       gain_prod
);

   localparam int SW      = pgl_pkg::SAMPLE_W;
   localparam int GW      = pgl_pkg::gain_reg_width(FRAC);
   localparam int AW      = pgl_pkg::alpha_reg_width(FRAC);
   localparam int FV_W    = pgl_pkg::fv_width(FRAC);
   localparam int GPROD_W = pgl_pkg::gprod_width(FRAC);
   localparam int DIFF_W  = FV_W + 1;
   localparam int PROD_W  = DIFF_W + AW + 1;
   localparam int RND_W   = PROD_W - FRAC + 1;
   localparam int SUM_W   = ((RND_W > FV_W) ? RND_W : FV_W) + 1;

   localparam logic signed [SUM_W-1:0] FV_HI =
      {{(SUM_W-FV_W+1){1'b0}}, {(FV_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] FV_LO = ~FV_HI;

   logic signed [FV_W-1:0]    fv_ff, fv_in;
   logic signed [GPROD_W-1:0] gprod_ff, gprod_in;
   logic signed [FV_W-1:0]    x_val;
   logic signed [DIFF_W-1:0]  diff;
   logic signed [PROD_W-1:0]  prod;
   logic signed [RND_W-1:0]   delta;
   logic signed [SUM_W-1:0]   sum;

   // scaled input minus running value
   assign x_val = $signed({{(FV_W-SW-FRAC){sample[SW-1]}}, sample, {FRAC{1'b0}}});
   assign diff  = $signed({x_val[FV_W-1], x_val}) - $signed({fv_ff[FV_W-1], fv_ff});

   // alpha times difference
   assign prod = $signed({{(PROD_W-DIFF_W){diff[DIFF_W-1]}}, diff})
               * $signed({{(PROD_W-AW){1'b0}}, alpha_coeff});

   pgl_round #(
      .W    (PROD_W),
      .FRAC (FRAC)
   ) u_delta_round (
      .value_in (prod),
      .result   (delta)
   );

   // accumulate and saturate the running value
   assign sum = $signed({{(SUM_W-RND_W){delta[RND_W-1]}}, delta})
              + $signed({{(SUM_W-FV_W){fv_ff[FV_W-1]}}, fv_ff});

   always_comb begin
      fv_in = fv_ff;
      if (ctrl.load && (ctrl.mode == pgl_pkg::MODE_LOWPASS)) begin
         if (sum > FV_HI) begin
            fv_in = FV_HI[FV_W-1:0];
         end else if (sum < FV_LO) begin
            fv_in = FV_LO[FV_W-1:0];
         end else begin
            fv_in = sum[FV_W-1:0];
         end
      end
   end

   // gain product
   assign gprod_in = $signed({{(GPROD_W-SW){sample[SW-1]}}, sample})
                   * $signed({{(GPROD_W-GW){gain_coeff[GW-1]}}, gain_coeff});

   always_ff @(posedge clock) begin
      if (reset) begin
         fv_ff <= '0;
      end else begin
         fv_ff <= fv_in;
      end
      if (ctrl.load) begin
         gprod_ff <= gprod_in;
      end
   end

   assign filter_value = fv_ff;
   assign gain_prod    = gprod_ff;

endmodule

FILE: dv/tb_pcm16_gain_and_one_pole_lowpass.sv
// testbench for the pcm16 gain and one-pole lowpass block: directed and random checks
`timescale 1ns / 1ps

module tb_pcm16_gain_and_one_pole_lowpass;

   localparam int     FRAC         = pgl_pkg::COEF_FRAC_BITS_DEF;
   localparam int     FV_BITS      = 17 + FRAC;
   localparam longint FV_MAX       = (64'sd1 <<< (FV_BITS - 1)) - 1;
   localparam longint FV_MIN       = -FV_MAX - 1;
   localparam longint OUT_MAX      = longint'(pgl_pkg::SAMPLE_MAX);
   localparam longint OUT_MIN      = longint'(pgl_pkg::SAMPLE_NEG_MAX);
   localparam longint UNITY        = 64'sd1 <<< FRAC;
   localparam logic [pgl_pkg::CSR_IDX_W-1:0] REG_UNUSED = 2'd3;
   localparam int     RANDOM_ITEMS = 900;
   localparam int     DRAIN_CYCLES = 8;
   localparam int     CYCLE_LIMIT  = 400000;

   typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PATTERN} stall_style_type;

   typedef struct {
      logic [pgl_pkg::SAMPLE_W-1:0] sample_in;
      logic [pgl_pkg::SAMPLE_W-1:0] sample_out;
   } sample_pair_type;

   logic                clock = 1'b0;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [15:0]         req_tdata;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b1;
   logic [15:0]         rsp_tdata;
   logic                csr_valid;
   logic                csr_ready;
   logic [pgl_pkg::CSR_IDX_W-1:0] csr_index;
   logic [pgl_pkg::GAIN_W-1:0]    csr_data;

   // predictor state and register copies
   logic                cfg_mode;
   longint              cfg_gain;
   longint              cfg_alpha;
   longint              lp_state;

   sample_pair_type     expected_samples[$];
   int                  mismatch_count = 0;
   int                  result_count   = 0;
   int                  cycle_count    = 0;

   // sender and receiver pacing
   int                  gap_max    = 0;
   int                  burst_left = 1;
   stall_style_type     stall_style = STALL_NONE;
   logic [15:0]         stall_pattern = 16'hFFFF;
   logic [3:0]          stall_pos = '0;
   logic [15:0]         last_sample = '0;

   pcm16_gain_and_one_pole_lowpass dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [15:0] sample_in
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // [15:0] sample_out
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // divide by 2^FRAC, ties to even, symmetric about zero
   function automatic longint round_half_even(longint v);
      logic   neg;
      longint mag;
      longint q;
      longint r;
      neg = (v < 0);
      mag = neg ? -v : v;
      q = mag >> FRAC;
      r = mag & (UNITY - 1);
      if (r > (UNITY >> 1) || (r == (UNITY >> 1) && q[0]))
         q++;
      return neg ? -q : q;
   endfunction

   // expected output for one sample, advances the running value in lowpass mode
   function automatic logic [pgl_pkg::SAMPLE_W-1:0] predict_sample(
      logic [pgl_pkg::SAMPLE_W-1:0] raw);
      longint s;
      longint y;
      longint diff;
      longint acc;
      s = longint'($signed(raw));
      if (s < OUT_MIN)
         s = OUT_MIN;
      if (cfg_mode == pgl_pkg::MODE_GAIN) begin
         y = round_half_even(s * cfg_gain);
      end else begin
         diff = s * UNITY - lp_state;
         acc = lp_state + round_half_even(diff * cfg_alpha);
         if (acc > FV_MAX)
            acc = FV_MAX;
         else if (acc < FV_MIN)
            acc = FV_MIN;
         lp_state = acc;
         y = round_half_even(lp_state);
      end
      if (y > OUT_MAX)
         y = OUT_MAX;
      else if (y < OUT_MIN)
         y = OUT_MIN;
      return y[pgl_pkg::SAMPLE_W-1:0];
   endfunction

   task automatic report_mismatch(string msg);
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
      mismatch_count++;
   endtask

   // watch all three channels: register writes, accepted samples, results
   always @(posedge clock) begin : monitor
      sample_pair_type head;
      logic [pgl_pkg::SAMPLE_W-1:0] want;
      if (reset) begin
         cfg_mode  = pgl_pkg::MODE_GAIN;
         cfg_gain  = UNITY;
         cfg_alpha = UNITY;
         lp_state  = 0;
         expected_samples.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               pgl_pkg::REG_MODE:  cfg_mode  = csr_data[0];
               pgl_pkg::REG_GAIN:  cfg_gain  = longint'($signed(csr_data));
               pgl_pkg::REG_ALPHA: cfg_alpha = longint'(csr_data[pgl_pkg::ALPHA_W-1:0]);
               default:   ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            want = predict_sample(req_tdata);
            expected_samples.push_back('{sample_in: req_tdata, sample_out: want});
         end
         if (rsp_tvalid && rsp_tready) begin
            result_count++;
            if (expected_samples.size() == 0) begin
               report_mismatch($sformatf("unexpected result %0d", $signed(rsp_tdata)));
            end else begin
               head = expected_samples.pop_front();
               if (rsp_tdata !== head.sample_out)
                  report_mismatch($sformatf("result %0d for input %0d: got %0d, want %0d",
                                            result_count, $signed(head.sample_in),
                                            $signed(rsp_tdata), $signed(head.sample_out)));
            end
         end
      end
   end

   // receiver backpressure
   always @(negedge clock) begin
      case (stall_style)
         STALL_RANDOM:  rsp_tready <= ($urandom_range(0, 99) < 65);
         STALL_PATTERN: rsp_tready <= stall_pattern[stall_pos];
         default:       rsp_tready <= 1'b1;
      endcase
      stall_pos <= stall_pos + 4'd1;
   end

   // wait until every expected result is in, then let the pipeline settle
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (expected_samples.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // register write, only from idle
   task automatic write_reg(logic [pgl_pkg::CSR_IDX_W-1:0] idx,
                            logic [pgl_pkg::GAIN_W-1:0] value);
      drain_results();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // present one item and hold it until taken, then maybe idle between bursts
   task automatic send_sample(logic [pgl_pkg::SAMPLE_W-1:0] value);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 24);
         gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   endtask

   function automatic logic [pgl_pkg::SAMPLE_W-1:0] random_sample();
      logic [pgl_pkg::SAMPLE_W-1:0] v;
      case ($urandom_range(0, 7))
         0: begin
            case ($urandom_range(0, 3))
               0: v = pgl_pkg::SAMPLE_MAX;
               1: v = pgl_pkg::SAMPLE_MOST_NEG;
               2: v = pgl_pkg::SAMPLE_NEG_MAX;
               default: v = '0;
            endcase
         end
         1: v = 16'($urandom_range(0, 8)) - 16'd4;
         2, 3: v = last_sample;
         default: v = 16'($urandom);
      endcase
      last_sample = v;
      return v;
   endfunction

   task automatic pick_pacing();
      case ($urandom_range(0, 3))
         0: begin
            gap_max = 0;
            stall_style = STALL_NONE;
         end
         1: begin
            gap_max = 3;
            stall_style = STALL_RANDOM;
         end
         2: begin
            gap_max = 10;
            stall_pattern = 16'($urandom) | 16'h0001;
            stall_style = STALL_PATTERN;
         end
         default: begin
            gap_max = 0;
            stall_pattern = 16'($urandom) | 16'h0001;
            stall_style = STALL_PATTERN;
         end
      endcase
   endtask

   // gain mode: unity after reset, extreme gains, ties, ignored register index
   task automatic test_gain_directed();
      gap_max = 2;
      stall_style = STALL_RANDOM;
      send_sample(16'd0);
      send_sample(pgl_pkg::SAMPLE_MAX);
      send_sample(pgl_pkg::SAMPLE_MOST_NEG);
      send_sample(16'hFFFF);
      write_reg(pgl_pkg::REG_GAIN, 24'h7FFFFF);
      send_sample(pgl_pkg::SAMPLE_MAX);
      send_sample(pgl_pkg::SAMPLE_MOST_NEG);
      write_reg(pgl_pkg::REG_GAIN, 24'h800000);
      send_sample(pgl_pkg::SAMPLE_MAX);
      send_sample(pgl_pkg::SAMPLE_MOST_NEG);
      // half gain puts odd inputs exactly on a tie
      write_reg(pgl_pkg::REG_GAIN, 24'h008000);
      write_reg(REG_UNUSED, 24'h123456);
      send_sample(16'd1);
      send_sample(16'd3);
      send_sample(16'hFFFF);
      send_sample(16'hFFFD);
      drain_results();
   endtask

   // lowpass mode: pass-through, hold, alpha above one into saturation, mode switch
   task automatic test_lowpass_directed();
      gap_max = 0;
      stall_style = STALL_NONE;
      write_reg(pgl_pkg::REG_MODE, 24'h000001);
      write_reg(pgl_pkg::REG_ALPHA, 24'h010000);
      send_sample(pgl_pkg::SAMPLE_MAX);
      send_sample(pgl_pkg::SAMPLE_MOST_NEG);
      write_reg(pgl_pkg::REG_ALPHA, 24'h000000);
      send_sample(16'd100);
      write_reg(pgl_pkg::REG_ALPHA, 24'hFFFFFF);
      send_sample(pgl_pkg::SAMPLE_MAX);
      send_sample(pgl_pkg::SAMPLE_MOST_NEG);
      send_sample(pgl_pkg::SAMPLE_MAX);
      write_reg(pgl_pkg::REG_ALPHA, 24'h000001);
      send_sample(16'd1);
      // upper data bits must not leak into the mode bit
      write_reg(pgl_pkg::REG_MODE, 24'hFFFFFE);
      send_sample(16'd5);
      write_reg(pgl_pkg::REG_MODE, 24'h000001);
      write_reg(pgl_pkg::REG_ALPHA, 24'h008000);
      send_sample(16'd0);
      drain_results();
   endtask

   // random settings per phase, random samples with held runs for the filter
   task automatic test_random_phases();
      int sent;
      int n;
      int g;
      logic [pgl_pkg::GAIN_W-1:0] value;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 3) != 0)
            write_reg(pgl_pkg::REG_MODE, (pgl_pkg::GAIN_W'($urandom) & 24'hFFFFFE)
                                         | pgl_pkg::GAIN_W'($urandom_range(0, 1)));
         if ($urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 5))
               0: value = pgl_pkg::GAIN_W'($urandom);
               1: begin
                  g = int'($urandom_range(0, 524288)) - 262144;
                  value = g[pgl_pkg::GAIN_W-1:0];
               end
               2: value = 24'h7FFFFF;
               3: value = 24'h800000;
               4: value = '0;
               default: begin
                  g = int'($urandom_range(0, 2097152)) - 1048576;
                  value = g[pgl_pkg::GAIN_W-1:0];
               end
            endcase
            write_reg(pgl_pkg::REG_GAIN, value);
         end
         if ($urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 5))
               0: value = pgl_pkg::GAIN_W'($urandom);
               1: value = 24'h010000;
               2: value = 24'h01FFFF;
               3: value = pgl_pkg::GAIN_W'($urandom_range(0, 1));
               default: value = pgl_pkg::GAIN_W'($urandom_range(0, 65536));
            endcase
            write_reg(pgl_pkg::REG_ALPHA, value);
         end
         if ($urandom_range(0, 7) == 0)
            write_reg(REG_UNUSED, pgl_pkg::GAIN_W'($urandom));
         pick_pacing();
         n = $urandom_range(10, 90);
         repeat (n) send_sample(random_sample());
         sent += n;
      end
      drain_results();
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_data   = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_gain_directed();
      test_lowpass_directed();
      test_random_phases();

      drain_results();
      if (mismatch_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

FILE: pcm16_gain_and_one_pole_lowpass.f
hw/rtl/pgl_pkg.sv
hw/rtl/pgl_round.sv
hw/rtl/pgl_filter.sv
hw/rtl/pcm16_gain_and_one_pole_lowpass.sv
dv/tb_pcm16_gain_and_one_pole_lowpass.sv
